[design/ers_pkg.sv]
// Package for the emission rate burst scheduler: command codes, register
// indexes, field widths and constants. No dependencies.
package ers_pkg;
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_PLAY    = 3'd1;
	localparam logic [2:0] CMD_PAUSE   = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;
	localparam logic [2:0] CMD_EMIT    = 3'd5;
	localparam logic [2:0] CMD_CONSUME = 3'd6;
	localparam logic [2:0] CMD_ADVANCE = 3'd7;

	localparam logic [2:0] REG_RATE     = 3'd0;
	localparam logic [2:0] REG_DURATION = 3'd1;
	localparam logic [2:0] REG_BTIME    = 3'd2;
	localparam logic [2:0] REG_BCOUNT   = 3'd3;
	localparam logic [2:0] REG_MAXP     = 3'd4;
	localparam logic [2:0] REG_LOOPING  = 3'd5;
	localparam logic [2:0] REG_AWAKE    = 3'd6;

	localparam logic [17:0] MAX_CAP      = 18'd200000;
	localparam logic [31:0] MIN_DURATION = 32'd7;
	localparam logic [29:0] SEQ_MASK     = 30'h3fffffff;

	// packed item layouts, first field highest
	typedef struct packed {
		logic        clear_on_stop;
		logic [19:0] count;
		logic [31:0] delta_time;
		logic [2:0]  command;
	} in_item_t;

	typedef struct packed {
		logic [18:0] emitted_now;
		logic        is_paused;
		logic        is_playing;
		logic [29:0] sequence_number;
		logic [17:0] ring_index;
		logic [31:0] pending_delta;
		logic        clear_flag;
		logic [17:0] live_estimate;
		logic [17:0] pending_emit;
	} out_item_t;
endpackage

[design/emission_rate_burst_scheduler.sv]
// Emission rate burst scheduler for a particle emitter.
// Sequencing: most commands go straight to the output load step; a tick that
// moves time runs 16 two-bit multiply steps, the burst check and a finish step,
// with 33 restoring modulo steps before finish when it wraps; advance runs those.
// Throughput: one item at a time; the next item is taken once the sequencer idles;
// a result waiting in the output register stalls only the final load step.
// Reset: arst_n clears all state and loads register reset values.
module emission_rate_burst_scheduler
	import ers_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[2:0], delta_time[34:3], count[54:35], clear_on_stop[55]
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pending_emit[17:0], live_estimate[35:18], clear_flag[36],
	// pending_delta[68:37], ring_index[86:69], sequence_number[116:87],
	// is_playing[117], is_paused[118], emitted_now[137:119]
	output logic [143:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_BST  = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	in_item_t  in_w;
	out_item_t res_q;
	assign in_w = in_item_t'(s_tdata);
	assign m_tdata = {6'd0, res_q};

	// configuration
	logic [31:0] rate_q, dur_q, btime_q;
	logic [19:0] bcount_q;
	logic [17:0] maxp_q;
	logic        loop_q, awake_q;
	// state
	logic [31:0] ptime_q, udelta_q;
	logic [31:0] racc_q;
	logic        play_q, pause_q, bdone_q, clr_q;
	logic [17:0] pend_q, live_q, cursor_q;
	logic [29:0] serial_q;
	// sequencer
	logic [2:0]  st_q;
	logic [5:0]  cnt_q;
	logic        mvalid_q;
	logic        adv_q;
	logic        cons_q;
	logic [31:0] step_q;
	logic [63:0] prod_q;
	logic [32:0] now_q;
	logic [32:0] rem_q;
	logic [32:0] dvd_q;
	logic [18:0] got_q;

	// configuration takes the idle slot first
	assign s_tready  = (st_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (st_q == ST_IDLE) && !mvalid_q;
	assign m_tvalid  = mvalid_q;

	// emit helper: saturating add of accepted count
	function automatic logic [17:0] sat_add(input logic [17:0] a, input logic [17:0] b,
		input logic [17:0] m);
		logic [18:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			sat_add = (s > {1'b0, m}) ? m : s[17:0];
		end
	endfunction

	function automatic logic [17:0] accept_n(input logic [32:0] n, input logic [17:0] m);
		accept_n = (n < {15'd0, m}) ? n[17:0] : m;
	endfunction

	// shared subtract unit for the restoring modulo
	logic [33:0] rem_sh;
	logic [33:0] dif;
	logic [33:0] divisor;
	assign divisor = adv_q ? {16'd0, maxp_q} : {2'd0, dur_q};
	assign rem_sh  = {rem_q, dvd_q[32]};
	assign dif     = rem_sh - divisor;

	// multiply step: two bits of step per cycle
	logic [33:0] pp;
	assign pp = {2'd0, rate_q} * {32'd0, step_q[1:0]};

	logic [32:0] low_w;
	logic [32:0] whole_w;
	logic [17:0] acc_w;
	logic [32:0] prev_w;
	assign low_w   = {1'b0, racc_q} + {1'b0, prod_q[31:0]};
	assign whole_w = {1'b0, prod_q[63:32]} + {32'd0, low_w[32]};
	assign acc_w   = accept_n(whole_w, maxp_q);
	assign prev_w  = {1'b0, ptime_q};

	logic [32:0] ud_sum;
	assign ud_sum = {1'b0, udelta_q} + {1'b0, in_w.delta_time};
	logic awake_w;
	assign awake_w = awake_q && !play_q && !pause_q && (ptime_q == 32'd0);
	logic [17:0] emit_acc;
	assign emit_acc = accept_n({13'd0, in_w.count}, maxp_q);
	logic [17:0] mclamp;
	assign mclamp = (cfg_data[17:0] == 18'd0) ? 18'd1 :
		(cfg_data[17:0] > MAX_CAP) ? MAX_CAP : cfg_data[17:0];

	// which commands need the iterative unit
	logic tick_go, adv_go;
	assign tick_go = (in_w.command == CMD_TICK) && (play_q || awake_w) && !pause_q
		&& !in_w.delta_time[31] && (in_w.delta_time != 32'd0);
	assign adv_go  = (in_w.command == CMD_ADVANCE) && (in_w.count != 20'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0; dur_q <= 32'd327680; btime_q <= '0; bcount_q <= '0;
			maxp_q <= 18'd1000; loop_q <= 1'b1; awake_q <= 1'b1;
			ptime_q <= '0; udelta_q <= '0; racc_q <= '0;
			play_q <= 1'b0; pause_q <= 1'b0; bdone_q <= 1'b0; clr_q <= 1'b0;
			pend_q <= '0; live_q <= '0; cursor_q <= '0; serial_q <= '0;
			st_q <= ST_IDLE; cnt_q <= '0; mvalid_q <= 1'b0; adv_q <= 1'b0;
			step_q <= '0; prod_q <= '0; now_q <= '0; rem_q <= '0; dvd_q <= '0;
			got_q <= '0; res_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					// configuration write
					if (cfg_valid && cfg_ready) begin
						unique case (cfg_index)
							REG_RATE:     rate_q <= cfg_data;
							REG_DURATION: dur_q <= (cfg_data < MIN_DURATION) ? MIN_DURATION : cfg_data;
							REG_BTIME:    btime_q <= cfg_data;
							REG_BCOUNT:   bcount_q <= cfg_data[19:0];
							REG_MAXP: begin
								maxp_q <= mclamp;
								if (live_q > mclamp) live_q <= mclamp;
							end
							REG_LOOPING:  loop_q <= cfg_data[0];
							REG_AWAKE:    awake_q <= cfg_data[0];
							default: ;
						endcase
					end
					if (s_tvalid && s_tready) begin
						got_q <= ((in_w.command == CMD_EMIT) && (in_w.count != 20'd0)) ?
							{1'b0, emit_acc} : '0;
						adv_q <= adv_go;
						st_q  <= tick_go ? ST_MUL : (adv_go ? ST_MOD : ST_OUT);
						unique case (in_w.command)
							CMD_TICK: begin
								if (awake_w) begin
									play_q <= 1'b1; pause_q <= 1'b0;
								end
								if (tick_go) begin
									step_q   <= in_w.delta_time;
									udelta_q <= ud_sum[32] ? 32'hffffffff : ud_sum[31:0];
									now_q    <= prev_w + {1'b0, in_w.delta_time};
									prod_q   <= '0;
									cnt_q    <= '0;
								end
							end
							CMD_PLAY:  begin play_q <= 1'b1; pause_q <= 1'b0; end
							CMD_PAUSE: begin play_q <= 1'b0; pause_q <= 1'b1; end
							CMD_STOP: begin
								play_q <= 1'b0; pause_q <= 1'b0; ptime_q <= '0;
								racc_q <= '0; udelta_q <= '0; bdone_q <= 1'b0;
								if (in_w.clear_on_stop) begin
									live_q <= '0; clr_q <= 1'b1; pend_q <= '0;
									cursor_q <= '0; serial_q <= '0;
								end
							end
							CMD_CLEAR: begin
								live_q <= '0; clr_q <= 1'b1; pend_q <= '0;
								cursor_q <= '0; serial_q <= '0;
							end
							CMD_EMIT: begin
								if (in_w.count != 20'd0) begin
									pend_q <= sat_add(pend_q, emit_acc, maxp_q);
									live_q <= sat_add(live_q, emit_acc, maxp_q);
								end
							end
							// zeroed as the result is loaded
							CMD_CONSUME: ;
							CMD_ADVANCE: begin
								if (adv_go) begin
									serial_q <= (serial_q + {10'd0, in_w.count}) & SEQ_MASK;
									dvd_q <= {15'd0, cursor_q} + {13'd0, in_w.count};
									rem_q <= '0;
									cnt_q <= 6'd0;
								end
							end
							default: ;
						endcase
					end
				end
				// rate product, two bits per cycle, LSB first
				ST_MUL: begin
					prod_q <= {pp + {2'd0, prod_q[63:32]}, prod_q[31:2]};
					step_q <= {2'd0, step_q[31:2]};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) st_q <= ST_BST;
				end
				// accumulate whole part, then burst check and end-of-duration handling
				ST_BST: begin : bst
					logic [17:0] p1, l1, p2, l2, a2;
					logic [18:0] g;
					logic        bd;
					p1 = pend_q; l1 = live_q; g = '0; bd = bdone_q;
					if (rate_q != 32'd0) begin
						racc_q <= low_w[31:0];
						if (whole_w != 33'd0) begin
							p1 = sat_add(p1, acc_w, maxp_q);
							l1 = sat_add(l1, acc_w, maxp_q);
							g  = {1'b0, acc_w};
						end
					end
					p2 = p1; l2 = l1;
					a2 = accept_n({13'd0, bcount_q}, maxp_q);
					if (bcount_q != 20'd0 && !bdone_q && prev_w <= {1'b0, btime_q}
						&& now_q >= {1'b0, btime_q}) begin
						p2 = sat_add(p1, a2, maxp_q);
						l2 = sat_add(l1, a2, maxp_q);
						g  = g + {1'b0, a2};
						bd = 1'b1;
					end
					pend_q <= p2; live_q <= l2; got_q <= g;
					if (now_q >= {1'b0, dur_q}) begin
						if (loop_q) begin
							bd = 1'b0;
							dvd_q <= now_q; rem_q <= '0; cnt_q <= '0;
							st_q <= ST_MOD;
						end else begin
							play_q <= 1'b0;
							ptime_q <= now_q[32] ? 32'hffffffff : now_q[31:0];
							st_q <= ST_FIN;
						end
					end else begin
						ptime_q <= now_q[31:0];
						st_q <= ST_FIN;
					end
					bdone_q <= bd;
				end
				// restoring modulo, one bit per cycle
				ST_MOD: begin
					rem_q <= dif[33] ? rem_sh[32:0] : dif[32:0];
					dvd_q <= {dvd_q[31:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						if (adv_q) cursor_q <= dif[33] ? rem_sh[17:0] : dif[17:0];
						else ptime_q <= dif[33] ? rem_sh[31:0] : dif[31:0];
						st_q <= ST_FIN;
					end
				end
				ST_FIN: st_q <= ST_OUT;
				// load result once the output register is free
				ST_OUT: begin
					if (!mvalid_q || m_tready) begin
						res_q.pending_emit    <= pend_q;
						res_q.live_estimate   <= live_q;
						res_q.clear_flag      <= clr_q;
						res_q.pending_delta   <= udelta_q;
						res_q.ring_index      <= cursor_q;
						res_q.sequence_number <= serial_q;
						res_q.is_playing      <= play_q;
						res_q.is_paused       <= pause_q;
						res_q.emitted_now     <= got_q;
						// consume reports the values before zeroing
						if (cons_q) begin
							pend_q <= '0; udelta_q <= '0; clr_q <= 1'b0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// output valid
			if (st_q == ST_OUT && (!mvalid_q || m_tready)) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cons_q <= 1'b0;
		else if (s_tvalid && s_tready) cons_q <= (in_w.command == CMD_CONSUME);
	end

	// assertions
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while waiting");
	a_live_cap: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= maxp_q) else $error("live count above capacity");
	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= MAX_CAP) else $error("pending count above limit");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_tready && !cfg_ready) else $error("ready while busy");
endmodule
